// ----- design/tse_pkg.sv -----
// ----------------------------------------------------------------------------
// tse_pkg
// Shared constants and types for the topological sort engine.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int MAX_NODES = 32;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;

  localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = CNT_W'(26);

  // action codes carried in tuser of the input channel
  localparam logic ACT_EDGE  = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef logic [MAX_NODES-1:0] row_t;

  // write request into the adjacency matrix
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    row_t             row;
  } mat_wr_t;

endpackage

// ----- design/tse_matrix.sv -----
// ----------------------------------------------------------------------------
// tse_matrix
// Adjacency bit matrix: one row per source vertex, synchronous read with data
// in the cycle after rd_en, and a valid bit per row so one clear empties all.
// ----------------------------------------------------------------------------
module tse_matrix (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [tse_pkg::IDX_W-1:0] rd_addr,
  output tse_pkg::row_t             rd_row,
  input  tse_pkg::mat_wr_t          wr,
  input  logic                      clear
);
  import tse_pkg::*;

  row_t                 mem [MAX_NODES];
  row_t                 rd_q;
  logic                 rd_valid;
  logic [MAX_NODES-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.row;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= row_valid[rd_addr];
    end
  end

  // a row never written since the last clear reads as no edges
  assign rd_row = rd_valid ? rd_q : '0;

endmodule

// ----- design/topological_sort_engine.sv -----
// ----------------------------------------------------------------------------
// topological_sort_engine
// Kahn-style topological sort over an adjacency bit matrix, sink first.
// ----------------------------------------------------------------------------
// Input stream: tuser is the action. An edge transaction (tuser 0) sets bit
// to_vertex of row from_vertex through a row read and then a row write back.
// A start transaction (tuser 1) runs the sort over vertex_count vertices
// (capped at 32). The run makes passes over the vertices in index order;
// each visit is one matrix read and then one check, and a run makes at
// most n passes, plus a cycle report if a pass emits nothing. The check
// waits on output stalls. The single matrix read port sets this scheme.
// Each emitted vertex is one output transaction; a pass with no emission
// gives one result with tuser (cycle found) set. tlast marks the final one.
// Input is taken only between runs and edge writes, one item at a time.
// A stalled receiver holds the result in the output register and the
// sequencer waits on the next emission. At the end of a run the matrix is
// cleared at once through per-row valid bits. Reset empties the matrix
// and sets vertex_count to 26; the config channel is always ready.
// ----------------------------------------------------------------------------
module topological_sort_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,   // from_vertex, to_vertex, zero fill
  input  logic                      s_axis_tuser,   // action
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // vertex_index, zero fill
  output logic                      m_axis_tuser,   // cycle_found
  output logic                      m_axis_tlast,   // last_result
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tse_pkg::CNT_W-1:0] cfg_data        // vertex_count
);
  import tse_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EDGE_WR = 3'd1;
  localparam logic [2:0] ST_RUN_RD  = 3'd2;
  localparam logic [2:0] ST_RUN_CHK = 3'd3;
  localparam logic [2:0] ST_CYC_OUT = 3'd4;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] n_sat;
  logic [IDX_W-1:0] edge_from;
  logic [IDX_W-1:0] edge_to;
  logic [IDX_W-1:0] idx, idx_next;
  row_t             done_mask, done_next;
  row_t             active, active_start;
  logic             progress, progress_next;

  logic             out_valid;
  logic [IDX_W-1:0] out_vertex;
  logic             out_cycle;
  logic             out_last;
  logic             out_free;

  logic             emit;
  logic [IDX_W-1:0] emit_vertex;
  logic             emit_cycle;
  logic             emit_last;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  row_t             rd_row;
  mat_wr_t          wr;
  logic             mat_clear;

  logic             in_take;
  logic [IDX_W-1:0] in_from;
  logic [IDX_W-1:0] in_to;
  logic             pass_end;
  row_t             idx_bit;
  row_t             done_set;
  logic [MAX_NODES:0] act_ext;

  tse_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr      (wr),
    .clear   (mat_clear)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_from       = s_axis_tdata[IDX_W-1:0];
  assign in_to         = s_axis_tdata[2*IDX_W-1:IDX_W];

  assign n_sat   = (vertex_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : vertex_count;
  assign act_ext = ({{MAX_NODES{1'b0}}, 1'b1} << n_sat) - (MAX_NODES+1)'(1);
  assign active_start = act_ext[MAX_NODES-1:0];

  assign out_free = !out_valid || m_axis_tready;
  assign pass_end = ((CNT_W'(idx) + CNT_W'(1)) == n_sat);
  assign idx_bit  = row_t'(1) << idx;
  assign done_set = done_mask | idx_bit;

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    done_next     = done_mask;
    progress_next = progress;
    emit          = 1'b0;
    emit_vertex   = idx;
    emit_cycle    = 1'b0;
    emit_last     = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx;
    wr.en         = 1'b0;
    wr.addr       = edge_from;
    wr.row        = rd_row | (row_t'(1) << edge_to);
    mat_clear     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (s_axis_tuser == ACT_EDGE) begin
            rd_en      = 1'b1;
            rd_addr    = in_from;
            state_next = ST_EDGE_WR;
          end else if (n_sat == '0) begin
            mat_clear  = 1'b1;
          end else begin
            idx_next      = '0;
            done_next     = '0;
            progress_next = 1'b0;
            state_next    = ST_RUN_RD;
          end
        end
      end
      ST_EDGE_WR: begin
        wr.en      = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RUN_RD: begin
        rd_en      = 1'b1;
        state_next = ST_RUN_CHK;
      end
      ST_RUN_CHK: begin
        if (done_mask[idx] || ((rd_row & active & ~done_mask) != '0) || out_free) begin
          if (!done_mask[idx] && ((rd_row & active & ~done_mask) == '0)) begin
            emit          = 1'b1;
            emit_last     = (done_set == active);
            done_next     = done_set;
            progress_next = 1'b1;
          end
          if (emit && emit_last) begin
            done_next  = '0;
            mat_clear  = 1'b1;
            state_next = ST_IDLE;
          end else if (pass_end) begin
            if (progress || emit) begin
              idx_next      = '0;
              progress_next = 1'b0;
              state_next    = ST_RUN_RD;
            end else begin
              state_next = ST_CYC_OUT;
            end
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = ST_RUN_RD;
          end
        end
      end
      ST_CYC_OUT: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_vertex = '0;
          emit_cycle  = 1'b1;
          emit_last   = 1'b1;
          done_next   = '0;
          mat_clear   = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= VERTEX_COUNT_RESET;
      idx          <= '0;
      done_mask    <= '0;
      progress     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      done_mask <= done_next;
      progress  <= progress_next;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      edge_from <= in_from;
      edge_to   <= in_to;
      active    <= active_start;
    end
    if (emit) begin
      out_vertex <= emit_vertex;
      out_cycle  <= emit_cycle;
      out_last   <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(8-IDX_W){1'b0}}, out_vertex};
  assign m_axis_tuser  = out_cycle;
  assign m_axis_tlast  = out_last;

`ifndef SYNTH
  // between runs no vertex is marked done
  a_idle_done_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (done_mask == '0))
    else $error("done mask not clear while idle");

  // a cycle report always closes the run
  a_cycle_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("cycle result without tlast");

  // within a run the done mask only gains vertices
  a_done_grows: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && $past(state) != ST_IDLE) |->
      ((done_mask & $past(done_mask)) == $past(done_mask)))
    else $error("done mask lost a vertex during a run");

  // a new result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> $stable(out_vertex) && $stable(out_last))
    else $error("stalled result overwritten");
`endif

endmodule
